[sv/rmq_pkg.sv]
`default_nettype none
package rmq_pkg;

  localparam int ElemW  = 16;
  localparam int RadW   = 18;             // radicand range up to 32767+2*32768+16384
  localparam int RootW  = 16;             // root fits 15 bits, kept unsigned
  localparam int DiffW  = 17;             // sum or difference of two elements
  localparam int NumW   = DiffW + 12;     // sum or difference scaled by 4096
  localparam int QuoW   = NumW;
  localparam int SqW    = 30;             // radicand << 12
  localparam int RootSteps = 15;          // result bits of the root
  localparam int QDepth = 4;
  localparam int QDepthW = 2;
  localparam int FrontLat = 2;            // default front stage count

  localparam logic signed [ElemW-1:0] QMax = 16'sh7fff;
  localparam logic signed [ElemW-1:0] QMin = -16'sh8000;
  localparam logic signed [RadW-1:0] OneQ14 = 18'sd16384;

  // index codes for the chosen root component
  localparam logic [1:0] IdxX = 2'd0;
  localparam logic [1:0] IdxY = 2'd1;
  localparam logic [1:0] IdxZ = 2'd2;
  localparam logic [1:0] IdxW = 2'd3;

  typedef struct packed {
    logic signed [ElemW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } mat_t;

  typedef struct packed {
    logic signed [ElemW-1:0] qw, qx, qy, qz;
    logic                    degenerate;
  } quat_t;

  // classified job handed from front to back
  typedef struct packed {
    logic [1:0]              root_idx;
    logic                    degen;
    logic [RadW-1:0]         rad;
    logic signed [DiffW-1:0] d0, d1, d2;   // numerators in component order
  } job_t;

endpackage
`default_nettype wire

[sv/rmq_if.sv]
`default_nettype none
interface rmq_mat_if;
  logic valid;
  logic ready;
  rmq_pkg::mat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rmq_quat_if;
  logic valid;
  logic ready;
  rmq_pkg::quat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/rmq_front.sv]
`default_nettype none
module rmq_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire rmq_pkg::mat_t in_data,
  input  wire logic          en,
  output rmq_pkg::job_t      job,
  output logic               job_valid
);
  import rmq_pkg::*;

  mat_t m_r;
  logic v1_r;
  logic signed [ElemW:0] tr01_r;
  job_t job_r;
  logic v2_r;

  logic signed [RadW-1:0] trace;
  logic [1:0] ii;
  logic signed [RadW-1:0] rad;
  job_t job_nxt;
  logic signed [ElemW-1:0] mii, mjj, mkk;

  // stage 1: register the matrix and a partial trace
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r    <= in_data;
      tr01_r <= (ElemW+1)'(in_data.m00) + (ElemW+1)'(in_data.m11);
      job_r  <= job_nxt;
    end
  end

  // stage 2: classify and form radicand and numerators
  always_comb begin
    trace = RadW'(tr01_r) + RadW'(m_r.m22);
    ii = IdxX;
    if (m_r.m11 > m_r.m00) ii = IdxY;
    if (ii == IdxX && m_r.m22 > m_r.m00) ii = IdxZ;
    if (ii == IdxY && m_r.m22 > m_r.m11) ii = IdxZ;
    mii = m_r.m00; mjj = m_r.m11; mkk = m_r.m22;
    job_nxt = '0;
    unique case (ii)
      IdxY: begin mii = m_r.m11; mjj = m_r.m22; mkk = m_r.m00; end
      IdxZ: begin mii = m_r.m22; mjj = m_r.m00; mkk = m_r.m11; end
      default: ;
    endcase
    if (trace > 0) begin
      rad = trace + OneQ14;
      job_nxt.root_idx = IdxW;
      job_nxt.d0 = DiffW'(m_r.m21) - DiffW'(m_r.m12);
      job_nxt.d1 = DiffW'(m_r.m02) - DiffW'(m_r.m20);
      job_nxt.d2 = DiffW'(m_r.m10) - DiffW'(m_r.m01);
    end else begin
      rad = RadW'(mii) - RadW'(mjj) - RadW'(mkk) + OneQ14;
      job_nxt.root_idx = ii;
      // d0 = w numerator, d1 = j, d2 = k
      unique case (ii)
        IdxY: begin
          job_nxt.d0 = DiffW'(m_r.m02) - DiffW'(m_r.m20);
          job_nxt.d1 = DiffW'(m_r.m21) + DiffW'(m_r.m12);
          job_nxt.d2 = DiffW'(m_r.m01) + DiffW'(m_r.m10);
        end
        IdxZ: begin
          job_nxt.d0 = DiffW'(m_r.m10) - DiffW'(m_r.m01);
          job_nxt.d1 = DiffW'(m_r.m02) + DiffW'(m_r.m20);
          job_nxt.d2 = DiffW'(m_r.m12) + DiffW'(m_r.m21);
        end
        default: begin
          job_nxt.d0 = DiffW'(m_r.m21) - DiffW'(m_r.m12);
          job_nxt.d1 = DiffW'(m_r.m10) + DiffW'(m_r.m01);
          job_nxt.d2 = DiffW'(m_r.m20) + DiffW'(m_r.m02);
        end
      endcase
    end
    job_nxt.degen = (rad <= 0);
    job_nxt.rad   = job_nxt.degen ? '0 : rad;
  end

  assign job = job_r;
  assign job_valid = v2_r;
endmodule
`default_nettype wire

[sv/rmq_fifo.sv]
`default_nettype none
module rmq_fifo #(
  parameter int Depth = rmq_pkg::QDepth
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire rmq_pkg::job_t wr_data,
  input  wire logic          rd_en,
  output rmq_pkg::job_t      rd_data,
  output logic               empty,
  output logic [$clog2(Depth):0] count
);
  import rmq_pkg::*;
  localparam int AW = $clog2(Depth);

  job_t mem_r [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;

  // small register queue, fall-through read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  assign rd_data = mem_r[rp_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;
endmodule
`default_nettype wire

[sv/rmq_back.sv]
`default_nettype none
module rmq_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          job_valid,
  input  wire rmq_pkg::job_t job,
  output logic               res_valid,
  output rmq_pkg::quat_t     res
);
  import rmq_pkg::*;
  localparam int NS = RootSteps;           // root pipeline stages
  localparam int NQ = QuoW;                // divider pipeline stages

  // root pipeline: one result bit per stage
  logic [NS:0]               rv_r;
  logic [SqW+1:0]            rrem_r [NS+1];
  logic [RootW-1:0]          rres_r [NS+1];
  job_t                      rjob_r [NS+1];

  always_comb begin
    rv_r[0] = job_valid;
    rrem_r[0] = {2'b0, job.rad, 12'b0};
    rres_r[0] = '0;
    rjob_r[0] = job;
  end

  for (genvar s = 0; s < NS; s++) begin : g_sq
    logic [SqW+1:0] trial;
    logic [SqW+1:0] rem_sh;
    always_comb begin
      rem_sh = rrem_r[s] >> (2*(NS-1-s));
      trial  = (SqW+2)'({rres_r[s], 2'b01});
    end
    always_ff @(posedge clk) begin
      if (!rst_n) rv_r[s+1] <= 1'b0;
      else if (en) rv_r[s+1] <= rv_r[s];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rjob_r[s+1] <= rjob_r[s];
        if (rem_sh >= trial) begin
          rrem_r[s+1] <= rrem_r[s] - (trial << (2*(NS-1-s)));
          rres_r[s+1] <= {rres_r[s][RootW-2:0], 1'b1};
        end else begin
          rrem_r[s+1] <= rrem_r[s];
          rres_r[s+1] <= {rres_r[s][RootW-2:0], 1'b0};
        end
      end
    end
  end

  // divider pipeline: three restoring dividers, one quotient bit per stage
  logic [NQ:0]      dv_r;
  logic [RootW-1:0] dc_r   [NQ+1];
  job_t             djob_r [NQ+1];
  logic [NumW-1:0]  dn_r   [3][NQ+1];
  logic [NumW-1:0]  dq_r   [3][NQ+1];
  logic [RootW:0]   dr_r   [3][NQ+1];
  logic [2:0]       dneg_r [NQ+1];

  always_comb begin
    dv_r[0] = rv_r[NS];
    dc_r[0] = rres_r[NS];
    djob_r[0] = rjob_r[NS];
  end

  // numerator magnitude and sign per lane
  for (genvar l = 0; l < 3; l++) begin : g_num
    logic signed [DiffW-1:0] d;
    logic signed [NumW-1:0] n;
    always_comb begin
      d = (l == 0) ? rjob_r[NS].d0 : (l == 1) ? rjob_r[NS].d1 : rjob_r[NS].d2;
      n = {d, 12'b0};
      dneg_r[0][l] = n[NumW-1];
      dn_r[l][0] = n[NumW-1] ? NumW'(-n) : NumW'(n);
      dq_r[l][0] = '0;
      dr_r[l][0] = '0;
    end
  end

  for (genvar s = 0; s < NQ; s++) begin : g_dv
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[s+1] <= 1'b0;
      else if (en) dv_r[s+1] <= dv_r[s];
    end
    for (genvar l = 0; l < 3; l++) begin : g_ln
      logic [RootW+1:0] sh;
      logic [RootW+1:0] sub;
      always_comb begin
        sh  = {dr_r[l][s], dn_r[l][s][NumW-1]};
        sub = sh - (RootW+2)'(dc_r[s]);
      end
      always_ff @(posedge clk) begin
        if (en) begin
          dn_r[l][s+1] <= dn_r[l][s] << 1;
          if (!sub[RootW+1]) begin
            dr_r[l][s+1] <= sub[RootW:0];
            dq_r[l][s+1] <= {dq_r[l][s][NumW-2:0], 1'b1};
          end else begin
            dr_r[l][s+1] <= sh[RootW:0];
            dq_r[l][s+1] <= {dq_r[l][s][NumW-2:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dc_r[s+1]   <= dc_r[s];
        djob_r[s+1] <= djob_r[s];
        dneg_r[s+1] <= dneg_r[s];
      end
    end
  end

  // sign restore, saturate and place components
  logic signed [ElemW-1:0] sat [3];
  logic signed [ElemW-1:0] root_s;
  quat_t res_nxt;
  quat_t res_r;
  logic  rv_out_r;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dneg_r[NQ][l]) begin
        sat[l] = (dq_r[l][NQ] > NumW'(32768)) ? QMin : ElemW'(-dq_r[l][NQ]);
      end else begin
        sat[l] = (dq_r[l][NQ] > NumW'(32767)) ? QMax : ElemW'(dq_r[l][NQ]);
      end
    end
    root_s = ElemW'(dc_r[NQ]);
    res_nxt = '0;
    unique case (djob_r[NQ].root_idx)
      IdxW: begin
        res_nxt.qw = root_s; res_nxt.qx = sat[0]; res_nxt.qy = sat[1]; res_nxt.qz = sat[2];
      end
      IdxX: begin
        res_nxt.qx = root_s; res_nxt.qw = sat[0]; res_nxt.qy = sat[1]; res_nxt.qz = sat[2];
      end
      IdxY: begin
        res_nxt.qy = root_s; res_nxt.qw = sat[0]; res_nxt.qz = sat[1]; res_nxt.qx = sat[2];
      end
      default: begin
        res_nxt.qz = root_s; res_nxt.qw = sat[0]; res_nxt.qx = sat[1]; res_nxt.qy = sat[2];
      end
    endcase
    if (djob_r[NQ].degen) res_nxt = '0;
    res_nxt.degenerate = djob_r[NQ].degen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rv_out_r <= 1'b0;
    else if (en) rv_out_r <= dv_r[NQ];
  end
  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

  assign res_valid = rv_out_r;
  assign res = res_r;
endmodule
`default_nettype wire

[sv/rotation_matrix_to_quaternion_unit.sv]
// path from accept to out_valid: front stages, queue fall-through, 15 root
//   stages, 29 divider stages and 1 output register
// throughput: one matrix word per cycle via fully pipelined root and divider
//   stages; credit holds input; whole back stalls on out_valid && !out_ready
// reset: synchronous active low rst_n clears valid bits and queue pointers
`default_nettype none
module rotation_matrix_to_quaternion_unit #(
  parameter int QueueDepth = rmq_pkg::QDepth
) (
  input wire logic clk,
  input wire logic rst_n,
  rmq_mat_if.sink    in_ch,
  rmq_quat_if.source out_ch
);
  import rmq_pkg::*;
  localparam int CW = $clog2(QueueDepth) + 1;
  localparam int Back = RootSteps + QuoW + 1;

  job_t f_job, q_job;
  logic f_valid, q_empty, back_en, q_rd;
  logic [CW-1:0] q_cnt;
  logic [CW+1:0] inflight_r;
  logic in_fire;

  // back pipeline runs whenever its output slot is free
  assign back_en = out_ch.ready || !out_ch.valid;
  assign q_rd = back_en && !q_empty;

  // credit: front items plus queue must fit the queue
  assign in_fire = in_ch.valid && in_ch.ready;
  always_ff @(posedge clk) begin
    if (!rst_n) inflight_r <= '0;
    else inflight_r <= inflight_r + (CW+2)'(in_fire) - (CW+2)'(q_rd);
  end
  assign in_ch.ready = (inflight_r < (CW+2)'(QueueDepth));

  rmq_front u_front (
    .clk, .rst_n,
    .in_valid(in_fire), .in_data(in_ch.data), .en(1'b1),
    .job(f_job), .job_valid(f_valid)
  );

  rmq_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk, .rst_n,
    .wr_en(f_valid), .wr_data(f_job),
    .rd_en(q_rd), .rd_data(q_job), .empty(q_empty), .count(q_cnt)
  );

  rmq_back u_back (
    .clk, .rst_n, .en(back_en),
    .job_valid(q_rd), .job(q_job),
    .res_valid(out_ch.valid), .res(out_ch.data)
  );

  // assertions
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt <= CW'(QueueDepth)) else $error("queue overflow");
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= (CW+2)'(QueueDepth)) else $error("credit overflow");
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.degenerate |-> out_ch.data.qw == '0 &&
    out_ch.data.qx == '0) else $error("degenerate nonzero");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped");
  a_back: assert property (@(posedge clk) disable iff (!rst_n)
    Back > 0 && q_rd |-> !q_empty) else $error("empty read");
endmodule
`default_nettype wire
